// ----- src/hpbam_pkg.sv -----
`default_nettype none

package hpbam_pkg;

	localparam int unsigned BLOCK_SHIFT = 12;
	localparam int unsigned OFFSET_W = 38;
	localparam int unsigned BLK_W = OFFSET_W - BLOCK_SHIFT;
	localparam int unsigned HASH_W = 32;
	localparam int unsigned HEADER_W = 32;
	localparam int unsigned TABLES_W = 2;
	localparam int unsigned LEVEL_W = 2;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned DEF_INDEX_BITS = 24;

	// 170 blocks per level-0 span; higher levels are powers of it
	localparam int unsigned LEVEL0_BLOCKS = 170;
	localparam int unsigned LEVEL1_BLOCKS = 28900;
	// ceil(log2(LEVEL0_BLOCKS)), extra precision of the reciprocal
	localparam int unsigned DIV_SHIFT = 8;

	localparam logic [HASH_W-1:0] STEP1_ONE = HASH_W'(LEVEL1_BLOCKS + (LEVEL0_BLOCKS + 1));
	localparam logic [HASH_W-1:0] STEP1_TWO =
		HASH_W'(LEVEL1_BLOCKS + 2 * (LEVEL0_BLOCKS + 1));

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HEADER_BYTES = 1'b0,
		REG_TABLES       = 1'b1
	} cfg_reg_t;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_0 = 2'd0,
		LVL_1 = 2'd1,
		LVL_2 = 2'd2,
		LVL_3 = 2'd3
	} tree_level_t;

	localparam int unsigned OUT_FIELDS_W = 3 * OFFSET_W + HASH_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- src/hashed_package_block_address_map_core.sv -----
// Block address map for a hash-tree package: each query (block number in
// s_axis_tdata, tree level in s_axis_tuser) returns the data byte offset, the
// hash block number at that level and the primary/secondary level-0 table
// offsets. One query is taken per clock while the output is not stalled; each
// result passes through the three reciprocal multipliers (divide by 170, by 170^2
// and by 170^3) in series followed by two adder stages. Configuration writes
// (header bytes at index 0, tables per level at index 1) are taken in any
// cycle and must only be issued while no query is in flight.
`default_nettype none

module hashed_package_block_address_map_core #(
	parameter int unsigned INDEX_BITS = hpbam_pkg::DEF_INDEX_BITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,

	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	// [INDEX_BITS-1:0] block_number, zero padded to bytes
	input  wire logic [((INDEX_BITS+7)/8)*8-1:0]         s_axis_tdata,
	// [1:0] tree_level
	input  wire logic [hpbam_pkg::LEVEL_W-1:0]           s_axis_tuser,

	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	// [37:0] data_byte_offset, [69:38] hash_block_index,
	// [107:70] primary_table_offset, [145:108] secondary_table_offset
	output logic [hpbam_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,

	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [hpbam_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [hpbam_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import hpbam_pkg::*;

	localparam int unsigned QW = INDEX_BITS - 7;
	localparam int unsigned PW = 2 * INDEX_BITS + 1;
	localparam int unsigned DIV_K = INDEX_BITS + DIV_SHIFT;
	localparam logic [INDEX_BITS:0] DIV_M = (INDEX_BITS + 1)'(
		((64'd1 << DIV_K) + 64'(LEVEL0_BLOCKS) - 64'd1) / 64'(LEVEL0_BLOCKS));

	logic [HEADER_W-1:0] header_q;
	logic [TABLES_W-1:0] tables_q;
	logic                tpl_two;
	logic [HASH_W-1:0]   tpl_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			tables_q <= TABLES_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER_BYTES: header_q <= HEADER_W'(cfg_data);
				REG_TABLES:       tables_q <= cfg_data[TABLES_W-1:0];
				default: ;
			endcase
		end
	end

	// 0 counts as one table, 3 as two
	assign tpl_two = tables_q[1];
	assign tpl_w = tpl_two ? HASH_W'(2) : HASH_W'(1);

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v5_s5 || m_axis_tready;
	assign rdy4 = !v4_s4 || rdy5;
	assign rdy3 = !v3_s3 || rdy4;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// stage 1: bi * reciprocal
	logic [INDEX_BITS-1:0] bi_s1;
	logic [LEVEL_W-1:0]    lvl_s1;
	logic [PW-1:0]         p0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (rdy1) v1_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			bi_s1  <= s_axis_tdata[INDEX_BITS-1:0];
			lvl_s1 <= s_axis_tuser;
			p0_s1  <= PW'(s_axis_tdata[INDEX_BITS-1:0]) * PW'(DIV_M);
		end
	end

	// stage 2: q0 = bi / 170, q0 * reciprocal, q0 * step0
	logic [QW-1:0]         q0_c;
	logic [INDEX_BITS-1:0] bi_s2;
	logic [LEVEL_W-1:0]    lvl_s2;
	logic [QW-1:0]         q0_s2;
	logic [PW-1:0]         p1_s2;
	logic [HASH_W-1:0]     h0m_s2;

	assign q0_c = p0_s1[DIV_K +: QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_s2 <= 1'b0;
		else if (rdy2) v2_s2 <= v1_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			bi_s2  <= bi_s1;
			lvl_s2 <= lvl_s1;
			q0_s2  <= q0_c;
			p1_s2  <= PW'(q0_c) * PW'(DIV_M);
			h0m_s2 <= HASH_W'(q0_c) * HASH_W'(LEVEL0_BLOCKS) + (HASH_W'(q0_c) << tpl_two);
		end
	end

	// stage 3: q1 = bi / 28900, q1 * reciprocal, q1 * step1
	logic [QW-1:0]         q1_c;
	logic [INDEX_BITS-1:0] bi_s3;
	logic [LEVEL_W-1:0]    lvl_s3;
	logic [QW-1:0]         q0_s3, q1_s3;
	logic [PW-1:0]         p2_s3;
	logic [HASH_W-1:0]     h0m_s3, h1m_s3;

	assign q1_c = p1_s2[DIV_K +: QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_s3 <= 1'b0;
		else if (rdy3) v3_s3 <= v2_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			bi_s3  <= bi_s2;
			lvl_s3 <= lvl_s2;
			q0_s3  <= q0_s2;
			q1_s3  <= q1_c;
			h0m_s3 <= h0m_s2;
			p2_s3  <= PW'(q1_c) * PW'(DIV_M);
			h1m_s3 <= HASH_W'(q1_c) * (tpl_two ? STEP1_TWO : STEP1_ONE);
		end
	end

	// stage 4: block numbers
	logic [QW-1:0]     q2_c;
	logic [BLK_W-1:0]  db_c;
	logic [HASH_W-1:0] h0_c, h1_c, step0_c, hsel_c;
	logic [BLK_W-1:0]  db_s4, h0_s4, h0n_s4;
	logic [HASH_W-1:0] hash_s4;

	assign q2_c = p2_s3[DIV_K +: QW];
	assign step0_c = HASH_W'(LEVEL0_BLOCKS) + tpl_w;

	always_comb begin
		db_c = BLK_W'(bi_s3) + ((BLK_W'(q0_s3) + BLK_W'(1)) << tpl_two);
		if (q0_s3 != '0)
			db_c = db_c + ((BLK_W'(q1_s3) + BLK_W'(1)) << tpl_two);
		if (q1_s3 != '0)
			db_c = db_c + ((BLK_W'(q2_c) + BLK_W'(1)) << tpl_two);

		if (q0_s3 == '0)
			h0_c = '0;
		else
			h0_c = h0m_s3 + ((HASH_W'(q1_s3) + HASH_W'(1)) << tpl_two)
				+ ((q1_s3 != '0) ? tpl_w : '0);

		h1_c = (q1_s3 == '0) ? step0_c : h1m_s3 + tpl_w;

		case (tree_level_t'(lvl_s3))
			LVL_0:   hsel_c = h0_c;
			LVL_1:   hsel_c = h1_c;
			default: hsel_c = tpl_two ? STEP1_TWO : STEP1_ONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v4_s4 <= 1'b0;
		else if (rdy4) v4_s4 <= v3_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			db_s4   <= db_c;
			hash_s4 <= hsel_c;
			h0_s4   <= h0_c[BLK_W-1:0];
			h0n_s4  <= h0_c[BLK_W-1:0] + BLK_W'(tpl_two);
		end
	end

	// stage 5: byte offsets
	logic [BLK_W-1:0]    base_c;
	logic [OFFSET_W-1:0] data_off_s5, prim_off_s5, sec_off_s5;
	logic [HASH_W-1:0]   hash_s5;

	assign base_c = BLK_W'(header_q[HEADER_W-1:BLOCK_SHIFT])
		+ BLK_W'(|header_q[BLOCK_SHIFT-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v5_s5 <= 1'b0;
		else if (rdy5) v5_s5 <= v4_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			data_off_s5 <= {base_c + db_s4, BLOCK_SHIFT'(0)};
			prim_off_s5 <= {base_c + h0_s4, BLOCK_SHIFT'(0)};
			sec_off_s5  <= {base_c + h0n_s4, BLOCK_SHIFT'(0)};
			hash_s5     <= hash_s4;
		end
	end

	assign m_axis_tvalid = v5_s5;
	assign m_axis_tdata = OUT_TDATA_W'({sec_off_s5, prim_off_s5, hash_s5, data_off_s5});

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v5_s5 && !m_axis_tready) |=> v5_s5)
		else $error("result dropped while stalled");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && v2_s2 && v3_s3 && v4_s4 && v5_s5 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken into a full pipeline");

	a_offsets_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (data_off_s5[BLOCK_SHIFT-1:0] == '0
			&& prim_off_s5[BLOCK_SHIFT-1:0] == '0 && sec_off_s5[BLOCK_SHIFT-1:0] == '0))
		else $error("offset not block aligned");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_s4 && rdy5) |=> v5_s5)
		else $error("item lost between stages four and five");

endmodule

`default_nettype wire

// ----- test/hashed_package_block_address_map_core_tb.sv -----
`timescale 1ns / 1ps

module hashed_package_block_address_map_core_tb;
	import hpbam_pkg::*;

	localparam int unsigned LEVEL2_BLOCKS = 4913000;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned RANDOM_PER_PHASE = 110;
	localparam int unsigned PHASES = 7;

	typedef struct packed {
		logic [OFFSET_W-1:0] secondary;
		logic [OFFSET_W-1:0] primary;
		logic [HASH_W-1:0]   hash_idx;
		logic [OFFSET_W-1:0] data_off;
	} map_result_t;

	typedef struct {
		logic [23:0] blk;
		tree_level_t lvl;
		bit          literal;
		map_result_t want;
	} query_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [LEVEL_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [HEADER_W-1:0] header_cfg;
	logic [TABLES_W-1:0] tables_cfg;

	map_result_t expected_maps[$];
	query_row_t query_table[$];
	bit failed;
	bit tx_idle_en;
	bit rx_idle_en;
	bit hold_req;
	int unsigned quiet_cycles;

	hashed_package_block_address_map_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned tree_hash_block(int unsigned bi, tree_level_t lvl,
			int unsigned tpl);
		int unsigned step0;
		int unsigned step1;
		int unsigned h;
		step0 = LEVEL0_BLOCKS + tpl;
		step1 = LEVEL1_BLOCKS + (LEVEL0_BLOCKS + 1) * tpl;
		case (lvl)
			LVL_0: begin
				if (bi < LEVEL0_BLOCKS)
					return 0;
				h = (bi / LEVEL0_BLOCKS) * step0 + (bi / LEVEL1_BLOCKS + 1) * tpl;
				if (bi >= LEVEL1_BLOCKS)
					h = h + tpl;
				return h;
			end
			LVL_1: begin
				if (bi < LEVEL1_BLOCKS)
					return step0;
				return (bi / LEVEL1_BLOCKS) * step1 + tpl;
			end
			default: return step1;
		endcase
	endfunction

	function automatic map_result_t map_block_address(logic [23:0] blk_no, tree_level_t lvl);
		int unsigned bi;
		int unsigned tpl;
		longint unsigned base;
		longint unsigned phys;
		longint unsigned span;
		map_result_t r;
		bi = 32'(blk_no);
		// zero tables acts as one, three as two
		tpl = (tables_cfg == 2'd0) ? 1 : (tables_cfg == 2'd3) ? 2 : 32'(tables_cfg);
		base = ({32'd0, header_cfg} + 64'd4095) & ~64'd4095;
		phys = 64'(bi);
		for (int i = 0; i < 3; i++) begin
			span = 64'((i == 0) ? LEVEL0_BLOCKS : (i == 1) ? LEVEL1_BLOCKS : LEVEL2_BLOCKS);
			phys = phys + ((64'(bi) + span) / span) * 64'(tpl);
			if (64'(bi) < span)
				break;
		end
		r.data_off = OFFSET_W'(base + (phys << BLOCK_SHIFT));
		r.hash_idx = tree_hash_block(bi, lvl, tpl);
		r.primary = OFFSET_W'(base +
			(longint'(tree_hash_block(bi, LVL_0, tpl)) << BLOCK_SHIFT));
		r.secondary = (tpl == 2) ? r.primary + OFFSET_W'(4096) : r.primary;
		return r;
	endfunction

	task automatic add_row(logic [23:0] blk, tree_level_t lvl, bit literal,
			logic [OFFSET_W-1:0] data_off, logic [HASH_W-1:0] hash_idx,
			logic [OFFSET_W-1:0] primary, logic [OFFSET_W-1:0] secondary);
		query_row_t row;
		row.blk = blk;
		row.lvl = lvl;
		row.literal = literal;
		row.want.data_off = data_off;
		row.want.hash_idx = hash_idx;
		row.want.primary = primary;
		row.want.secondary = secondary;
		query_table.push_back(row);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_HEADER_BYTES)
			header_cfg = val;
		else
			tables_cfg = val[TABLES_W-1:0];
		@(posedge clk);
	endtask

	task automatic send_query(logic [23:0] blk, tree_level_t lvl, bit literal,
			map_result_t want);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= blk;
		s_axis_tuser <= lvl;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_maps.push_back(literal ? want : map_block_address(blk, lvl));
	endtask

	// result checker
	always @(posedge clk) begin
		map_result_t got;
		map_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[OUT_FIELDS_W-1:0];
			if (expected_maps.size() == 0) begin
				$error("unexpected result transaction: %h", got);
				failed = 1'b1;
			end else begin
				want = expected_maps.pop_front();
				if (got.data_off !== want.data_off) begin
					$error("data_byte_offset: expected %h, actual %h", want.data_off,
						got.data_off);
					failed = 1'b1;
				end
				if (got.hash_idx !== want.hash_idx) begin
					$error("hash_block_index: expected %h, actual %h", want.hash_idx,
						got.hash_idx);
					failed = 1'b1;
				end
				if (got.primary !== want.primary) begin
					$error("primary_table_offset: expected %h, actual %h", want.primary,
						got.primary);
					failed = 1'b1;
				end
				if (got.secondary !== want.secondary) begin
					$error("secondary_table_offset: expected %h, actual %h",
						want.secondary, got.secondary);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on transaction activity
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("hashed_package_block_address_map_core verification failed");
			$finish;
		end
	end

	// receiver
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [23:0] blk;
		tree_level_t lvl;
		int unsigned span;
		map_result_t none;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		failed = 1'b0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req = 1'b0;
		quiet_cycles = 0;
		header_cfg = '0;
		tables_cfg = 2'd1;
		none = '0;

		// literal rows hold at the reset setting: no header, one table per level
		add_row(24'd0, LVL_0, 1'b1, 38'd4096, 32'd0, 38'd0, 38'd0);
		add_row(24'd0, LVL_1, 1'b1, 38'd4096, 32'd171, 38'd0, 38'd0);
		add_row(24'd0, LVL_2, 1'b1, 38'd4096, 32'd29071, 38'd0, 38'd0);
		add_row(24'd0, LVL_3, 1'b1, 38'd4096, 32'd29071, 38'd0, 38'd0);
		add_row(24'd169, LVL_0, 1'b0, '0, '0, '0, '0);
		add_row(24'd170, LVL_0, 1'b0, '0, '0, '0, '0);
		add_row(24'd171, LVL_1, 1'b0, '0, '0, '0, '0);
		add_row(24'd28899, LVL_0, 1'b0, '0, '0, '0, '0);
		add_row(24'd28900, LVL_0, 1'b0, '0, '0, '0, '0);
		add_row(24'd28900, LVL_1, 1'b0, '0, '0, '0, '0);
		add_row(24'd4912999, LVL_0, 1'b0, '0, '0, '0, '0);
		add_row(24'd4913000, LVL_1, 1'b0, '0, '0, '0, '0);
		add_row(24'd9826000, LVL_2, 1'b0, '0, '0, '0, '0);
		add_row(24'hFFFFFF, LVL_0, 1'b0, '0, '0, '0, '0);
		add_row(24'hFFFFFF, LVL_1, 1'b0, '0, '0, '0, '0);
		add_row(24'hFFFFFF, LVL_3, 1'b0, '0, '0, '0, '0);
		add_row(24'hAAAAAA, LVL_2, 1'b0, '0, '0, '0, '0);
		add_row(24'h555555, LVL_1, 1'b0, '0, '0, '0, '0);

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: begin
					write_register(REG_HEADER_BYTES, 32'hFFFF_FFFF);
					write_register(REG_TABLES, 32'd2);
				end
				2: begin
					write_register(REG_HEADER_BYTES, 32'd1);
					write_register(REG_TABLES, 32'd0);
				end
				3: begin
					write_register(REG_HEADER_BYTES, 32'd4096);
					write_register(REG_TABLES, 32'd3);
				end
				4: begin
					write_register(REG_HEADER_BYTES, $urandom);
					write_register(REG_TABLES,
						{30'($urandom_range(0, 32'h3FFF_FFFF)), 2'd1});
				end
				5: begin
					write_register(REG_HEADER_BYTES, $urandom);
					write_register(REG_TABLES,
						{30'($urandom_range(0, 32'h3FFF_FFFF)), 2'd2});
				end
				6: begin
					tx_idle_en = 1'b0;
					rx_idle_en = 1'b0;
					write_register(REG_HEADER_BYTES, 32'hFFFF_F001);
					write_register(REG_TABLES, 32'($urandom_range(0, 3)));
				end
				default: ;
			endcase

			if (phase == 0) begin
				foreach (query_table[i])
					send_query(query_table[i].blk, query_table[i].lvl,
						query_table[i].literal, query_table[i].want);
			end

			if (phase == 1) begin
				tx_idle_en = 1'b0;
				hold_req = 1'b1;
			end

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (phase == 1 && n == 40)
					tx_idle_en = 1'b1;
				case ($urandom_range(0, 3))
					0: blk = 24'($urandom_range(0, 40000));
					1: begin
						span = ($urandom_range(0, 2) == 0) ? LEVEL0_BLOCKS :
							($urandom_range(0, 1) == 0) ? LEVEL1_BLOCKS : LEVEL2_BLOCKS;
						blk = 24'(span * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
					end
					default: blk = 24'($urandom);
				endcase
				lvl = tree_level_t'($urandom_range(0, 3));
				send_query(blk, lvl, 1'b0, none);
			end
			s_axis_tvalid <= 1'b0;

			wait (expected_maps.size() == 0);
			repeat (8)
				@(posedge clk);
		end

		if (!failed) begin
			$display("hashed_package_block_address_map_core verification clean");
		end else begin
			$display("hashed_package_block_address_map_core verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/hpbam_pkg.sv
src/hashed_package_block_address_map_core.sv
test/hashed_package_block_address_map_core_tb.sv
